### rtl/ucs_pkg.sv
// Shared types, codes and helpers for the UTF-8 character substitution block.
package ucs_pkg;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOOK,
        OP_EOT,
        OP_WRITE,
        OP_CLEAR
    } op_t;

    localparam logic [1:0] CMD_TEXT  = 2'd0;
    localparam logic [1:0] CMD_EOT   = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_OVERWROTE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_CLEARED   = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    // Token that walks the row of table cells.
    typedef struct packed {
        op_t         op;
        logic [31:0] key;
        logic [2:0]  klen;
        logic [63:0] rep;
        logic [3:0]  rlen;
        logic        hit;
        logic [2:0]  wstat;
    } token_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd1;
        if (b >= 8'hC0 && b <= 8'hDF) len = 3'd2;
        if (b >= 8'hE0 && b <= 8'hEF) len = 3'd3;
        if (b >= 8'hF0 && b <= 8'hF7) len = 3'd4;
        return len;
    endfunction

endpackage

### rtl/ucs_gather.sv
// Front end: gathers UTF-8 bytes into characters and forms table tokens.
module ucs_gather
    import ucs_pkg::*;
#(
    parameter int MAX_OUT_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         accept,
    input  logic [1:0]   command,
    input  logic [7:0]   text_byte,
    input  logic [31:0]  key_code,
    input  logic [2:0]   key_length,
    input  logic [63:0]  replacement,
    input  logic [3:0]   replacement_length,
    output token_t       tok
);
    localparam logic [3:0] MaxOut = 4'(MAX_OUT_BYTES);

    logic [31:0] buf_reg, buf_next;
    logic [2:0]  held_reg, held_next;
    logic [2:0]  need_reg, need_next;

    logic [31:0] cbuf;
    logic [2:0]  chel, cneed, kl;

    always_comb begin
        buf_next  = buf_reg;
        held_next = held_reg;
        need_next = need_reg;
        tok       = '0;
        tok.op    = OP_NOP;
        tok.wstat = ST_FULL;
        cbuf  = buf_reg;
        chel  = held_reg;
        cneed = need_reg;
        kl    = key_length;
        if (accept) begin
            unique case (command)
                CMD_TEXT: begin
                    if (held_reg == 3'd0) begin
                        cneed = lead_length(text_byte);
                        cbuf  = {24'd0, text_byte};
                    end else begin
                        cbuf = buf_reg | ({24'd0, text_byte} << {held_reg[1:0], 3'd0});
                    end
                    chel = held_reg + 3'd1;
                    if (chel >= cneed) begin
                        tok.op    = OP_LOOK;
                        tok.key   = cbuf;
                        tok.klen  = cneed;
                        buf_next  = '0;
                        held_next = '0;
                        need_next = '0;
                    end else begin
                        buf_next  = cbuf;
                        held_next = chel;
                        need_next = cneed;
                    end
                end
                CMD_EOT: begin
                    tok.op    = OP_EOT;
                    tok.key   = buf_reg;
                    tok.klen  = held_reg;
                    buf_next  = '0;
                    held_next = '0;
                    need_next = '0;
                end
                CMD_WRITE: begin
                    if (kl == 3'd0) kl = 3'd1;
                    if (kl > 3'd4)  kl = 3'd4;
                    tok.op   = OP_WRITE;
                    tok.klen = kl;
                    tok.key  = (kl == 3'd4) ? key_code
                             : key_code & ((32'd1 << {kl[1:0], 3'd0}) - 32'd1);
                    tok.rep  = replacement;
                    tok.rlen = (replacement_length > MaxOut) ? MaxOut : replacement_length;
                end
                CMD_CLEAR: tok.op = OP_CLEAR;
                default: tok.op = OP_NOP;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            held_reg <= '0;
            need_reg <= '0;
        end else begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
            need_reg <= need_next;
        end
    end

endmodule

### rtl/ucs_cell.sv
// One table slot: matches, inserts or clears as each token passes by.
module ucs_cell
    import ucs_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  token_t tok_in,
    output token_t tok_out
);
    logic        v_reg;
    logic [31:0] k_reg;
    logic [2:0]  kl_reg;
    logic [63:0] r_reg;
    logic [3:0]  rl_reg;
    token_t      tok_reg, tok_next;
    logic        match;

    assign match   = v_reg && kl_reg == tok_in.klen && k_reg == tok_in.key;
    assign tok_out = tok_reg;

    always_comb begin
        tok_next = tok_in;
        if (tok_in.op == OP_LOOK && match) begin
            tok_next.hit  = 1'b1;
            tok_next.rep  = r_reg;
            tok_next.rlen = rl_reg;
        end
        // Valid slots always form a prefix, so a key never sits past the first free slot.
        if (tok_in.op == OP_WRITE && !tok_in.hit && (match || !v_reg)) begin
            tok_next.hit   = 1'b1;
            tok_next.wstat = match ? ST_OVERWROTE : ST_INSERTED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg      <= 1'b0;
            tok_reg.op <= OP_NOP;
        end else if (adv) begin
            tok_reg <= tok_next;
            if (tok_in.op == OP_CLEAR) v_reg <= 1'b0;
            if (tok_in.op == OP_WRITE && !tok_in.hit && (match || !v_reg)) begin
                v_reg  <= 1'b1;
                k_reg  <= tok_in.key;
                kl_reg <= tok_in.klen;
                r_reg  <= tok_in.rep;
                rl_reg <= tok_in.rlen;
            end
        end
    end

endmodule

### rtl/ucs_emit.sv
// Tail: expands each token into output words and keeps the sticky warning.
module ucs_emit
    import ucs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  token_t     tail,
    output logic       load,
    output logic       o_valid,
    input  logic       o_ready,
    output logic       o_kind,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic [2:0] o_status,
    output logic       o_unm
);
    token_t     e_reg;
    logic       ev_reg;
    logic [3:0] n_reg, n_next;
    logic [3:0] idx_reg;
    logic       warn_reg;
    logic       unm_reg;
    logic       take;

    assign o_valid = ev_reg;
    assign o_last  = idx_reg == n_reg - 4'd1;
    assign take    = o_valid && o_ready;
    assign load    = !ev_reg || (take && o_last);

    always_comb begin
        unique case (tail.op)
            OP_LOOK:  n_next = tail.hit ? tail.rlen : {1'b0, tail.klen};
            OP_EOT:   n_next = {1'b0, tail.klen} + 4'd1;
            OP_WRITE, OP_CLEAR: n_next = 4'd1;
            default:  n_next = 4'd0;
        endcase
    end

    always_comb begin
        o_kind   = 1'b0;
        o_status = 3'd0;
        o_unm    = 1'b0;
        o_byte   = '0;
        unique case (e_reg.op)
            OP_LOOK: o_byte = e_reg.hit ? e_reg.rep[{idx_reg[2:0], 3'd0} +: 8]
                                        : e_reg.key[{idx_reg[1:0], 3'd0} +: 8];
            OP_EOT: begin
                if (o_last) begin
                    o_kind   = 1'b1;
                    o_status = ST_DONE;
                    o_unm    = unm_reg;
                end else begin
                    o_byte = e_reg.key[{idx_reg[1:0], 3'd0} +: 8];
                end
            end
            OP_WRITE: begin
                o_kind   = 1'b1;
                o_status = e_reg.wstat;
            end
            OP_CLEAR: begin
                o_kind   = 1'b1;
                o_status = ST_CLEARED;
            end
            default: o_byte = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_reg   <= 1'b0;
            warn_reg <= 1'b0;
            idx_reg  <= '0;
            n_reg    <= '0;
            e_reg.op <= OP_NOP;
        end else if (load) begin
            ev_reg  <= n_next != 4'd0;
            e_reg   <= tail;
            n_reg   <= n_next;
            idx_reg <= '0;
            if (tail.op == OP_LOOK && !tail.hit && tail.klen > 3'd1) warn_reg <= 1'b1;
            if (tail.op == OP_EOT) begin
                unm_reg  <= warn_reg || tail.klen != 3'd0;
                warn_reg <= 1'b0;
            end
        end else if (take) begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

endmodule

### rtl/utf8_character_substitution.sv
// Top level of the UTF-8 character substitution block.
//
//  channel | dir | tdata (low bit up)                                 | tuser    | tlast
//  s_      | in  | text_byte, key_code, key_length, replacement,       | command  | -
//          |     | replacement_length (111 bits, padded to 112)       |          |
//  m_      | out | out_byte, status, unmapped_multibyte (12 -> 16)    | kind     | last
//
// One word is accepted per cycle while the output side keeps up. Each word
// becomes a token that walks a row of TABLE_ENTRIES slot cells, one cell per
// cycle while the row advances, and then into the tail emitter's register.
// The emitter sends the token's output words one by one (up to MAX_OUT_BYTES
// for a replacement); while it drains, the whole row stalls and s_tready drops.
// Reset empties the table, the character buffer and the warning at once.
module utf8_character_substitution
    import ucs_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int MAX_OUT_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // text_byte[7:0], key_code[39:8], key_length[42:40], replacement[106:43],
    // replacement_length[110:107], zero pad [111]
    input  logic [111:0] s_tdata,
    // command[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_byte[7:0], status[10:8], unmapped_multibyte[11], zero pad [15:12]
    output logic [15:0]  m_tdata,
    // kind[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);
    logic       adv;
    token_t     chain [TABLE_ENTRIES+1];
    logic [7:0] o_byte;
    logic [2:0] o_status;
    logic       o_unm;

    assign s_tready = adv;

    ucs_gather #(.MAX_OUT_BYTES(MAX_OUT_BYTES)) u_gather (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .accept             (s_tvalid && adv),
        .command            (s_tuser),
        .text_byte          (s_tdata[7:0]),
        .key_code           (s_tdata[39:8]),
        .key_length         (s_tdata[42:40]),
        .replacement        (s_tdata[106:43]),
        .replacement_length (s_tdata[110:107]),
        .tok                (chain[0])
    );

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        ucs_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    ucs_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tail     (chain[TABLE_ENTRIES]),
        .load     (adv),
        .o_valid  (m_tvalid),
        .o_ready  (m_tready),
        .o_kind   (m_tuser[0]),
        .o_byte   (o_byte),
        .o_last   (m_tlast),
        .o_status (o_status),
        .o_unm    (o_unm)
    );

    assign m_tdata = {4'd0, o_unm, o_status, o_byte};

endmodule

### rtl/ucs_checker.sv
// Port-level checks for the substitution block, bound to the top level.
module ucs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled word changed");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("status word not last or has byte");

    a_warn_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> m_tuser[0] && m_tdata[10:8] == 3'd4)
        else $error("warning outside text done");
endmodule

bind utf8_character_substitution ucs_checker u_ucs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/sv/tb_top.sv
// Testbench for the UTF-8 character substitution block: directed and random stream traffic checked by a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ucs_pkg::*;

    localparam int SLOTS    = 64;
    localparam int MAX_REPL = 8;
    localparam int LATENCY  = SLOTS + 16;
    localparam int WATCHDOG = 20000;

    // One expected output word.
    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic       last;
        logic [2:0] status;
        logic       unmapped;
    } out_word_t;

    // Predictor plus store of expected output words.
    class subst_scoreboard;
        logic [31:0] keys [SLOTS];
        logic [2:0]  key_lens [SLOTS];
        logic [63:0] repls [SLOTS];
        logic [3:0]  repl_lens [SLOTS];
        bit          used [SLOTS];
        logic [31:0] char_buf;
        int          held;
        int          needed;
        bit          warn;
        out_word_t   pending [$];
        int          errors;

        function new();
            foreach (used[i]) used[i] = 0;
            char_buf = '0;
            held = 0;
            needed = 0;
            warn = 0;
            errors = 0;
        endfunction

        function void push(logic kind, logic [7:0] b, logic last, logic [2:0] st, logic u);
            out_word_t w;
            w.kind = kind; w.out_byte = b; w.last = last; w.status = st; w.unmapped = u;
            pending.push_back(w);
        endfunction

        function int lookup(logic [31:0] key, int len);
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && key_lens[i] == len && keys[i] == key) return i;
            return -1;
        endfunction

        function int char_len(logic [7:0] b);
            if (b >= 8'hC0 && b <= 8'hDF) return 2;
            if (b >= 8'hE0 && b <= 8'hEF) return 3;
            if (b >= 8'hF0 && b <= 8'hF7) return 4;
            return 1;
        endfunction

        // Apply one accepted input word.
        function void note_input(logic [1:0] cmd, logic [7:0] tb_byte, logic [31:0] key,
                                 logic [2:0] klen_in, logic [63:0] rep, logic [3:0] rlen_in);
            int slot, klen, rlen, free_slot;
            logic [2:0] st;
            case (cmd)
                CMD_TEXT: begin
                    if (held == 0) begin
                        needed = char_len(tb_byte);
                        char_buf = {24'd0, tb_byte};
                        held = 1;
                    end else begin
                        char_buf |= 32'(tb_byte) << (8 * held);
                        held++;
                    end
                    if (held >= needed) begin
                        slot = lookup(char_buf, needed);
                        if (slot >= 0) begin
                            for (int i = 0; i < repl_lens[slot]; i++)
                                push(1'b0, repls[slot][8*i +: 8], i + 1 == repl_lens[slot],
                                     3'd0, 1'b0);
                        end else begin
                            for (int i = 0; i < needed; i++)
                                push(1'b0, char_buf[8*i +: 8], i + 1 == needed, 3'd0, 1'b0);
                            if (needed > 1) warn = 1;
                        end
                        char_buf = '0; held = 0; needed = 0;
                    end
                end
                CMD_EOT: begin
                    for (int i = 0; i < held; i++)
                        push(1'b0, char_buf[8*i +: 8], 1'b0, 3'd0, 1'b0);
                    if (held > 0) warn = 1;
                    push(1'b1, 8'd0, 1'b1, ST_DONE, warn);
                    warn = 0; char_buf = '0; held = 0; needed = 0;
                end
                CMD_WRITE: begin
                    klen = (klen_in == 0) ? 1 : (klen_in > 4) ? 4 : klen_in;
                    rlen = (rlen_in > MAX_REPL) ? MAX_REPL : rlen_in;
                    if (klen < 4) key &= (32'd1 << (8 * klen)) - 1;
                    if (rlen < 8) rep &= (64'd1 << (8 * rlen)) - 1;
                    slot = lookup(key, klen);
                    if (slot >= 0) begin
                        st = ST_OVERWROTE;
                    end else begin
                        free_slot = -1;
                        for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) free_slot = i;
                        if (free_slot >= 0) begin
                            slot = free_slot;
                            used[slot] = 1;
                            keys[slot] = key;
                            key_lens[slot] = 3'(klen);
                            st = ST_INSERTED;
                        end else begin
                            st = ST_FULL;
                        end
                    end
                    if (slot >= 0) begin
                        repls[slot] = rep;
                        repl_lens[slot] = 4'(rlen);
                    end
                    push(1'b1, 8'd0, 1'b1, st, 1'b0);
                end
                default: begin
                    foreach (used[i]) used[i] = 0;
                    push(1'b1, 8'd0, 1'b1, ST_CLEARED, 1'b0);
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        // Compare one accepted output word with the oldest expectation.
        task check_output(logic kind, logic [7:0] b, logic last, logic [2:0] st, logic u);
            out_word_t w;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind=%0d byte=%02h", kind, b));
                return;
            end
            w = pending.pop_front();
            if (kind !== w.kind) report_mismatch($sformatf("kind %0d exp %0d", kind, w.kind));
            if (b !== w.out_byte)
                report_mismatch($sformatf("out_byte %02h exp %02h", b, w.out_byte));
            if (last !== w.last) report_mismatch($sformatf("last %0d exp %0d", last, w.last));
            if (st !== w.status) report_mismatch($sformatf("status %0d exp %0d", st, w.status));
            if (u !== w.unmapped)
                report_mismatch($sformatf("unmapped %0d exp %0d", u, w.unmapped));
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [1:0]   s_tuser = CMD_TEXT;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [15:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;

    subst_scoreboard sb;
    int  idle_cycles = 0;
    bit  stim_done = 0;
    bit  sink_stall_free = 0;

    always #10 aclk = ~aclk;

    utf8_character_substitution i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // Accepted words on both sides feed the scoreboard; watchdog counts dead cycles.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[42:40],
                              s_tdata[106:43], s_tdata[110:107]);
            if (m_tvalid && m_tready)
                sb.check_output(m_tuser[0], m_tdata[7:0], m_tlast, m_tdata[10:8], m_tdata[11]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (!s_tvalid && stim_done
                    && sb.pending.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stall before each word, with stall-free stretches.
    initial begin
        int gap;
        @(negedge aclk);
        forever begin
            gap = sink_stall_free ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Send one word after a random gap; valid stays high back to back.
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] tb_byte,
                             input logic [31:0] key, input logic [2:0] klen,
                             input logic [63:0] rep, input logic [3:0] rlen,
                             input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, rlen, rep, klen, key, tb_byte};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_text(input logic [7:0] b, input bit no_gap = 0);
        send_word(CMD_TEXT, b, $urandom, 3'($urandom), {$urandom, $urandom}, 4'($urandom),
                  no_gap);
    endtask

    task automatic send_write(input logic [31:0] key, input logic [2:0] klen,
                              input logic [63:0] rep, input logic [3:0] rlen);
        send_word(CMD_WRITE, 8'($urandom), key, klen, rep, rlen);
    endtask

    // Wait until all expected words have drained, then let the pipe go quiet.
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY) @(negedge aclk);
    endtask

    // Random character whose lead byte picks the length; the other bytes are random.
    function automatic logic [31:0] rand_char(output int len);
        logic [31:0] c;
        len = $urandom_range(1, 4);
        c = $urandom;
        case (len)
            1: c[7:0] = 8'($urandom_range(0, 8'h7F));
            2: c[7:0] = 8'($urandom_range(8'hC0, 8'hDF));
            3: c[7:0] = 8'($urandom_range(8'hE0, 8'hEF));
            default: c[7:0] = 8'($urandom_range(8'hF0, 8'hF7));
        endcase
        return c;
    endfunction

    initial begin
        logic [31:0] keybook [8];
        int          keylen [8];
        int          len, pick, r;
        logic [31:0] c;

        sb = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: inserts, overwrite, clamped lengths, deletion, partial flush.
        send_write(32'h0000_0041, 3'd1, 64'hFFEE_DDCC_BBAA_9988, 4'd8);
        send_write(32'hFFFF_A9C3, 3'd2, 64'h0000_0000_0000_0065, 4'd1);
        send_write(32'h1234_56E2, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send_write(32'h8080_80F0, 3'd7, 64'h0, 4'd0);
        send_write(32'h0000_0041, 3'd1, 64'h0123_4567_89AB_CDEF, 4'd8);
        send_text(8'h41);
        send_text(8'hC3); send_text(8'hA9);
        send_text(8'hF0, 1'b1); send_text(8'h80, 1'b1); send_text(8'h80, 1'b1);
        send_text(8'h80, 1'b1);
        send_text(8'h56);
        send_text(8'h00); send_text(8'hFF); send_text(8'hF8);
        send_text(8'hC3); send_text(8'hAA);
        send_word(CMD_EOT, '0, '0, '0, '0, '0);
        send_text(8'hE2); send_text(8'h82);
        send_word(CMD_EOT, '0, '0, '0, '0, '0);
        send_word(CMD_EOT, '0, '0, '0, '0, '0);
        send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
        send_text(8'h41);
        drain();

        // Fill past capacity to reach the table-full status.
        sink_stall_free = 1;
        for (int i = 0; i <= SLOTS; i++)
            send_word(CMD_WRITE, '0, 32'(i) << 8 | 32'hC0, 3'd2, {$urandom, $urandom},
                      4'($urandom_range(0, 8)), 1'b1);
        send_text(8'hC0); send_text(8'h05);
        send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
        sink_stall_free = 0;
        drain();

        // Random part: mostly complete characters over a small key set.
        foreach (keybook[i]) begin
            keybook[i] = rand_char(keylen[i]);
            send_write(keybook[i], 3'(keylen[i]), {$urandom, $urandom},
                       4'($urandom_range(0, 9)));
        end
        for (int n = 0; n < 12; n++) begin
            r = $urandom_range(0, 99);
            if (n == 6) drain();
            if (r < 55) begin
                pick = $urandom_range(0, 7);
                c = ($urandom_range(0, 1) != 0) ? keybook[pick] : rand_char(len);
                if (c == keybook[pick]) len = keylen[pick];
                for (int k = 0; k < len; k++) send_text(c[8*k +: 8], $urandom_range(0, 3) == 0);
            end else if (r < 75) begin
                send_text(8'($urandom));
            end else if (r < 85) begin
                send_word(CMD_EOT, '0, '0, '0, '0, '0);
            end else if (r < 97) begin
                pick = $urandom_range(0, 7);
                send_write(($urandom_range(0, 1) != 0) ? keybook[pick] : $urandom,
                           3'($urandom), {$urandom, $urandom}, 4'($urandom));
            end else begin
                send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
            end
        end
        send_word(CMD_EOT, '0, '0, '0, '0, '0);
        stim_done = 1;
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/ucs_pkg.sv
rtl/ucs_gather.sv
rtl/ucs_cell.sv
rtl/ucs_emit.sv
rtl/utf8_character_substitution.sv
rtl/ucs_checker.sv
tb/sv/tb_top.sv
